// ===== src/rog_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the rank ordered set.
// No dependencies; every other file imports this package.
package rog_pkg;

  localparam int CAPACITY = 64;
  localparam int KEY_W    = 32;
  localparam int POS_W    = 6;
  localparam int RANK_W   = 7;
  localparam int STAT_W   = 2;

  // Index of one cell, and an entry count that can hold CAPACITY itself.
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  // Common width for comparing a delete position against indexes and counts.
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] ST_NO_RANK = 2'd2;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic                    load;     // latch the compare result for a new item
    logic signed [KEY_W-1:0] cmp_key;  // key of the item being accepted
    logic [CNT_W-1:0]        count;    // current number of stored entries
    logic                    ins;      // commit an insert
    logic signed [KEY_W-1:0] ins_key;  // key being inserted
    logic                    del;      // commit a delete
    logic [POS_W-1:0]        pos;      // rank being deleted
  } cell_cmd_t;

endpackage

// ===== src/rog_cell.sv =====
`timescale 1ns / 1ps
// One storage cell of the sorted chain: holds one key and its compare flag.
// Depends on rog_pkg.
module rog_cell
  import rog_pkg::*;
(
  input  logic                    clk,
  input  logic [IDX_W-1:0]        index,
  input  cell_cmd_t               cmd,
  input  logic                    prev_gt,
  input  logic signed [KEY_W-1:0] prev_key,
  input  logic signed [KEY_W-1:0] next_key,
  output logic signed [KEY_W-1:0] key,
  output logic                    gt
);

  logic occupied;
  logic at_or_after_pos;

  assign occupied        = CNT_W'(index) < cmd.count;
  assign at_or_after_pos = CMP_W'(index) >= CMP_W'(cmd.pos);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      gt <= occupied && (key > cmd.cmp_key);
    end
  end

  // Insert: entries greater than the new key stay, the boundary cell takes the
  // new key and the rest shift down by one. Delete: shift up from the position.
  always_ff @(posedge clk) begin
    if (cmd.ins && !gt) begin
      key <= prev_gt ? cmd.ins_key : prev_key;
    end else if (cmd.del && at_or_after_pos) begin
      key <= next_key;
    end
  end

endmodule

// ===== src/rog_rank_enc.sv =====
`timescale 1ns / 1ps
// Turns the thermometer of compare flags along the chain into a rank.
// Depends on rog_pkg.
module rog_rank_enc
  import rog_pkg::*;
(
  input  logic [CAPACITY-1:0] gt,
  output logic [CNT_W-1:0]    rank
);

  logic [CAPACITY+1:0] ext;

  // Flags run 1...10...0 from cell 0; pad with a 1 before and a 0 after so
  // exactly one boundary exists, and its place is the rank.
  assign ext = {1'b0, gt, 1'b1};

  always_comb begin
    rank = '0;
    for (int j = 0; j <= CAPACITY; j++) begin
      if (ext[j] && !ext[j+1]) begin
        rank = rank | CNT_W'(j);
      end
    end
  end

endmodule

// ===== src/rank_ordered_set.sv =====
`timescale 1ns / 1ps
// Rank ordered set: a chain of cells holding keys sorted largest first.
// Each item is handled in order: the accept edge latches the compare in every
// cell, and the finish edge, taken once the result register is free, shifts
// the chain and loads the result register; a new item waits until finish.
// Synchronous reset empties the set; key storage is not cleared.
module rank_ordered_set
  import rog_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    operation,
  input  logic signed [KEY_W-1:0] key,
  input  logic [POS_W-1:0]        position,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [RANK_W-1:0]       rank,
  output logic [STAT_W-1:0]       status
);

  logic                    busy;
  logic                    op_q;
  logic signed [KEY_W-1:0] key_q;
  logic [POS_W-1:0]        pos_q;
  logic [CNT_W-1:0]        count;

  logic                    accept;
  logic                    finish;
  logic                    full;
  logic                    del_ok;
  cell_cmd_t               cmd;
  logic [CAPACITY-1:0]     gt;
  logic signed [KEY_W-1:0] keys [CAPACITY];
  logic [CNT_W-1:0]        ins_rank;

  assign in_stall = busy;
  assign accept   = in_valid && !busy;
  assign finish   = busy && (!out_valid || !out_stall);
  assign full     = count == CNT_W'(CAPACITY);
  assign del_ok   = CMP_W'(pos_q) < CMP_W'(count);

  always_comb begin
    cmd.load    = accept;
    cmd.cmp_key = key;
    cmd.count   = count;
    cmd.ins     = finish && (op_q == OP_INSERT) && !full;
    cmd.ins_key = key_q;
    cmd.del     = finish && (op_q == OP_DELETE) && del_ok;
    cmd.pos     = pos_q;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                    prev_gt;
    logic signed [KEY_W-1:0] prev_key;
    logic signed [KEY_W-1:0] next_key;

    if (i == 0) begin : g_first
      assign prev_gt  = 1'b1;
      assign prev_key = key_q;
    end else begin : g_mid
      assign prev_gt  = gt[i-1];
      assign prev_key = keys[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_key = keys[i];
    end else begin : g_inner
      assign next_key = keys[i+1];
    end

    rog_cell u_cell (
      .clk      (clk),
      .index    (IDX_W'(i)),
      .cmd      (cmd),
      .prev_gt  (prev_gt),
      .prev_key (prev_key),
      .next_key (next_key),
      .key      (keys[i]),
      .gt       (gt[i])
    );
  end

  rog_rank_enc u_rank_enc (
    .gt   (gt),
    .rank (ins_rank)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q  <= operation;
      key_q <= key;
      pos_q <= position;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (finish) begin
        busy <= 1'b0;
      end

      if (cmd.ins) begin
        count <= count + 1'b1;
      end else if (cmd.del) begin
        count <= count - 1'b1;
      end

      if (finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      if (op_q == OP_INSERT) begin
        rank   <= RANK_W'(ins_rank);
        status <= full ? ST_FULL : ST_OK;
      end else begin
        rank   <= '0;
        status <= del_ok ? ST_OK : ST_NO_RANK;
      end
    end
  end

endmodule

// ===== src/rog_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for rank_ordered_set, bound to the top level.
// Depends on rog_pkg.
module rog_checker
  import rog_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    operation,
  input logic signed [KEY_W-1:0] key,
  input logic [POS_W-1:0]        position,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [RANK_W-1:0]       rank,
  input logic [STAT_W-1:0]       status
);

  // The block works on one item at a time, so an accept is always followed
  // by a stalled cycle.
  a_stall_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after an accepted item");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_FULL || status == ST_NO_RANK))
    else $error("unknown status code");

  a_missing_rank_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_NO_RANK |-> rank == '0)
    else $error("failed delete reports a nonzero rank");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(rank) && $stable(status))
    else $error("stalled result changed");

endmodule

bind rank_ordered_set rog_checker u_rog_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .operation (operation),
  .key       (key),
  .position  (position),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .rank      (rank),
  .status    (status)
);

// ===== bench/tb_rank_ordered_set.sv =====
`timescale 1ns / 1ps
// Self-checking bench for rank_ordered_set: random insert/delete traffic with
// an in-bench sorted store that predicts every rank and status.
// Depends on rog_pkg and the rank_ordered_set RTL.
module tb_rank_ordered_set;
  import rog_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1600;
  localparam int HOLD_START = 500;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic                    kind;
    logic signed [KEY_W-1:0] key_val;
    logic [POS_W-1:0]        pos;
    int                      gap;
    bit                      drain;
  } stim_t;

  typedef struct {
    logic [RANK_W-1:0] rank_v;
    logic [STAT_W-1:0] stat_v;
  } outcome_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic                    operation = OP_INSERT;
  logic signed [KEY_W-1:0] key = '0;
  logic [POS_W-1:0]        position = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [RANK_W-1:0]       rank;
  logic [STAT_W-1:0]       status;

  rank_ordered_set uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .key       (key),
    .position  (position),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .rank      (rank),
    .status    (status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  stim_t    op_queue[$];
  outcome_t due_outcomes[$];

  // Predicted contents of the block, largest key first.
  logic signed [KEY_W-1:0] set_keys [CAPACITY];
  int set_count = 0;

  int gen_count = 0;
  int stim_total = 0;
  int items_in = 0;
  int results_seen = 0;
  int errors = 0;
  int cycles = 0;
  int stall_left = 0;
  logic long_hold = 1'b0;
  logic hold_done = 1'b0;
  int hold_cycles = 0;
  stim_t nxt;
  outcome_t want;

  // Applies one accepted item to the predicted store and records its outcome.
  task automatic track_op(input logic kind, input logic signed [KEY_W-1:0] k,
                          input logic [POS_W-1:0] p);
    outcome_t res;
    int gt;
    res.rank_v = '0;
    res.stat_v = ST_OK;
    gt = 0;
    if (kind == OP_INSERT) begin
      for (int i = 0; i < set_count; i++)
        if (set_keys[i] > k) gt++;
      res.rank_v = gt[RANK_W-1:0];
      if (set_count >= CAPACITY) begin
        res.stat_v = ST_FULL;
      end else begin
        // A new key lands after every stored key that is greater, ahead of equal ones.
        for (int i = set_count; i > gt; i--) set_keys[i] = set_keys[i-1];
        set_keys[gt] = k;
        set_count++;
      end
    end else begin
      if (int'(p) >= set_count) begin
        res.stat_v = ST_NO_RANK;
      end else begin
        for (int i = int'(p); i + 1 < set_count; i++) set_keys[i] = set_keys[i+1];
        set_count--;
      end
    end
    due_outcomes.push_back(res);
  endtask

  // Queues one item and keeps a running entry count for choosing positions.
  function automatic void queue_item(input logic kind, input logic signed [KEY_W-1:0] k,
                                     input logic [POS_W-1:0] p, input int gap,
                                     input bit drain);
    stim_t s;
    s.kind = kind;
    s.key_val = k;
    s.pos = p;
    s.gap = gap;
    s.drain = drain;
    op_queue.push_back(s);
    if (!drain) begin
      stim_total++;
      if (kind == OP_INSERT) begin
        if (gen_count < CAPACITY) gen_count++;
      end else if (int'(p) < gen_count) begin
        gen_count--;
      end
    end
  endfunction

  // Mix of full-range keys, a narrow band that forces duplicates, and extremes.
  function automatic logic signed [KEY_W-1:0] pick_key();
    int sel;
    sel = $urandom_range(9, 0);
    if (sel < 5) return $urandom;
    if (sel < 8) return int'($urandom_range(8, 0)) - 4;
    case ($urandom_range(3, 0))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  initial begin
    int phase_no;
    int mode;
    int len;
    int ins_pct;
    int g;
    bit quiet;
    bit mid_drained;
    logic [POS_W-1:0] pos_r;

    // Directed opening: empty delete, extremes, duplicates, out-of-range ranks.
    queue_item(OP_DELETE, $urandom, 6'd0, 0, 0);
    queue_item(OP_INSERT, 32'h0000_0000, POS_W'($urandom), $urandom_range(13, 0), 0);
    queue_item(OP_INSERT, 32'h7FFF_FFFF, POS_W'($urandom), $urandom_range(13, 0), 0);
    queue_item(OP_INSERT, 32'h8000_0000, POS_W'($urandom), 0, 0);
    queue_item(OP_INSERT, 32'hFFFF_FFFF, POS_W'($urandom), 0, 0);
    queue_item(OP_INSERT, 32'h0000_0000, POS_W'($urandom), $urandom_range(13, 0), 0);
    queue_item(OP_INSERT, 32'h7FFF_FFFF, POS_W'($urandom), 0, 0);
    queue_item(OP_INSERT, 32'h8000_0000, POS_W'($urandom), 0, 0);
    queue_item(OP_DELETE, $urandom, 6'd63, $urandom_range(13, 0), 0);
    queue_item(OP_DELETE, $urandom, 6'd7, 0, 0);
    queue_item(OP_DELETE, $urandom, 6'd6, 0, 0);
    queue_item(OP_DELETE, $urandom, 6'd0, $urandom_range(13, 0), 0);
    queue_item(OP_DELETE, $urandom, 6'd2, 0, 0);
    queue_item(OP_INSERT, 32'h0000_0001, POS_W'($urandom), 0, 0);
    queue_item(OP_INSERT, 32'hFFFF_FFFE, POS_W'($urandom), $urandom_range(13, 0), 0);
    queue_item(OP_INSERT, 32'h7FFF_FFFE, POS_W'($urandom), 0, 0);
    queue_item(OP_INSERT, 32'h8000_0001, POS_W'($urandom), 0, 0);
    queue_item(OP_DELETE, $urandom, 6'd3, 0, 0);
    queue_item(OP_INSERT, 32'h5555_5555, POS_W'($urandom), 0, 0);
    queue_item(OP_INSERT, 32'hAAAA_AAAA, POS_W'($urandom), 0, 0);
    queue_item(OP_DELETE, $urandom, 6'd0, 0, 0);
    queue_item(OP_INSERT, '0, '0, 0, 1);

    // Random phases: the first one overfills the store, later ones lean
    // toward filling, emptying, or a balanced mix.
    phase_no = 0;
    mid_drained = 1'b0;
    while (stim_total < RANDOM_ITEMS) begin
      mode = (phase_no == 0) ? 0 : $urandom_range(2, 0);
      len = (phase_no == 0) ? 80 : $urandom_range(120, 40);
      quiet = (phase_no % 3 == 2);
      ins_pct = (mode == 0) ? 90 : (mode == 1) ? 10 : 55;
      for (int j = 0; j < len; j++) begin
        g = quiet ? 0 : $urandom_range(13, 0);
        if ($urandom_range(99, 0) < ins_pct) begin
          queue_item(OP_INSERT, pick_key(), POS_W'($urandom), g, 0);
        end else begin
          if (gen_count > 0 && $urandom_range(99, 0) < 85)
            pos_r = POS_W'($urandom_range(gen_count - 1, 0));
          else
            pos_r = POS_W'($urandom);
          queue_item(OP_DELETE, $urandom, pos_r, g, 0);
        end
      end
      if (!mid_drained && stim_total >= RANDOM_ITEMS / 2) begin
        queue_item(OP_INSERT, '0, '0, 0, 1);
        mid_drained = 1'b1;
      end
      phase_no++;
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (!(op_queue.size() == 0 && !in_valid && due_outcomes.size() == 0))
      @(posedge clk);
    repeat (16) @(posedge clk);
    if (errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Driver: presents queued items, honoring per-item gaps and drain points.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        track_op(operation, key, position);
        items_in <= items_in + 1;
      end
      if (!in_valid || !in_stall) begin
        if (op_queue.size() == 0) begin
          in_valid <= 1'b0;
        end else if (op_queue[0].drain) begin
          in_valid <= 1'b0;
          if (due_outcomes.size() == 0) void'(op_queue.pop_front());
        end else if (op_queue[0].gap > 0) begin
          in_valid <= 1'b0;
          op_queue[0].gap = op_queue[0].gap - 1;
        end else begin
          nxt = op_queue.pop_front();
          in_valid <= 1'b1;
          operation <= nxt.kind;
          key <= nxt.key_val;
          position <= nxt.pos;
        end
      end
    end
  end

  // One long receiver hold-off while the sender keeps offering items.
  always @(posedge clk) begin
    if (rst) begin
      long_hold <= 1'b0;
      hold_done <= 1'b0;
      hold_cycles <= 0;
    end else if (!hold_done && items_in >= HOLD_START) begin
      long_hold <= (hold_cycles != HOLD_CYCLES - 1);
      hold_done <= (hold_cycles == HOLD_CYCLES - 1);
      hold_cycles <= hold_cycles + 1;
    end
  end

  // Monitor: checks each accepted result against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_outcomes.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got rank %0d status %0d",
                   $time, rank, status);
        end else begin
          want = due_outcomes.pop_front();
          if (rank !== want.rank_v) begin
            errors++;
            $display("%0t: rank mismatch, expected %0d, got %0d", $time, want.rank_v, rank);
          end
          if (status !== want.stat_v) begin
            errors++;
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.stat_v, status);
          end
        end
        results_seen++;
        stall_left = ((results_seen / 96) % 3 == 1) ? 0 : $urandom_range(13, 0);
      end
      if (long_hold) begin
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule
